>>> rtl/shrb_pkg.sv
`default_nettype none

package shrb_pkg;

    // fixed field widths
    localparam int TOTAL_W  = 40;
    localparam int CAP_W    = 15;
    localparam int SMP_W    = 16;
    localparam int ACTION_W = 2;

    // parameter defaults
    localparam int STORE_DEPTH_DEF = 16384;
    localparam int READ_BURST_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 16;

    // configuration register
    localparam logic [CAP_W-1:0] CAP_RESET   = 15'd16000;
    localparam logic             CFG_IDX_CAP = 1'b0;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_READ   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;

    typedef struct packed {
        logic [ACTION_W-1:0]     action;
        logic signed [SMP_W-1:0] sample_in;
        logic [TOTAL_W-1:0]      start_index;
        logic [TOTAL_W-1:0]      end_index;
    } t_shrb_in;

    typedef struct packed {
        logic signed [SMP_W-1:0] sample_out;
        logic                    sample_valid;
        logic                    last;
        logic                    truncated;
        logic [TOTAL_W-1:0]      total_count;
        logic [CAP_W-1:0]        stored_count;
    } t_shrb_out;

    // shared adder/subtractor operation and result
    typedef struct packed {
        logic [TOTAL_W-1:0] a;
        logic [TOTAL_W-1:0] b;
        logic               sub;
    } t_alu_op;

    typedef struct packed {
        logic [TOTAL_W-1:0] sum;
        logic               borrow;
        logic               zero;
    } t_alu_res;

endpackage

`default_nettype wire

>>> rtl/shrb_ram.sv
`default_nettype none

module shrb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16384
) (
    input  wire                       i_clk,
    input  wire                       i_we,
    input  wire [$clog2(DEPTH)-1:0]   i_waddr,
    input  wire [WIDTH-1:0]           i_wdata,
    input  wire                       i_re,
    input  wire [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [WIDTH-1:0]          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/shrb_addsub.sv
`default_nettype none

module shrb_addsub (
    input  wire shrb_pkg::t_alu_op i_op,
    output shrb_pkg::t_alu_res o_res
);

    import shrb_pkg::*;

    logic [TOTAL_W:0] w_full;

    // a - b as a + ~b + 1, carry out high means no borrow
    always_comb begin
        w_full = {1'b0, i_op.a}
               + {1'b0, (i_op.sub ? ~i_op.b : i_op.b)}
               + {{TOTAL_W{1'b0}}, i_op.sub};
        o_res.sum    = w_full[TOTAL_W-1:0];
        o_res.borrow = i_op.sub & ~w_full[TOTAL_W];
        o_res.zero   = (w_full[TOTAL_W-1:0] == '0);
    end

endmodule

`default_nettype wire

>>> rtl/sample_history_range_buffer.sv
// Ring history of the most recent samples with absolute-index range reads. An append or a
// clear item answers with one status item, so appends stream at one per clock while the
// output side keeps up. A read item runs a ten-step setup on a single shared 40-bit
// adder/subtractor (window bounds, clipping, burst count, start address), then returns each
// sample through the registered read port of the sample memory, a read state then an output
// state per sample. An empty result comes when the range is reversed or empty or nothing is
// held, or when clipping to the stored window leaves nothing. No new item is accepted while
// a read runs. The memory content is undefined after reset and needs no clearing pass; only
// written entries are ever read. capacity_samples is written over the APB-style port at byte
// address 0, only while the block is idle.
`default_nettype none

module sample_history_range_buffer #(
    parameter int STORE_DEPTH = shrb_pkg::STORE_DEPTH_DEF,
    parameter int READ_BURST  = shrb_pkg::READ_BURST_DEF,
    parameter int SAMPLE_BITS = shrb_pkg::SAMPLE_BITS_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    // input item channel
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  wire shrb_pkg::t_shrb_in i_in_data,
    // result item channel
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output shrb_pkg::t_shrb_out  o_out_data,
    // configuration port
    input  wire                  psel,
    input  wire                  penable,
    input  wire                  pwrite,
    input  wire [2:0]            paddr,
    input  wire [31:0]           pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    import shrb_pkg::*;

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int CW = $clog2(READ_BURST + 1);
    localparam logic [TOTAL_W-1:0] DEPTH_T = TOTAL_W'(STORE_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHK,      // end <= start or nothing held
        S_FIRST,    // first = total - held, floored at zero
        S_LAST,     // one past newest = first + held
        S_CLIPS,    // clip start to first, keep offset
        S_CLIPE,    // clip end to one past newest
        S_CNT,      // count = end - start, cut to burst
        S_BASE,     // oldest slot = write pointer - held
        S_WRAP1,    // fold negative slot back into the ring
        S_OFS,      // add offset of first returned sample
        S_WRAP2,    // fold slot past the ring end
        S_RD,       // memory read issued
        S_OUT,      // sample into output register
        S_EMPTY     // single invalid result
    } t_state;

    // sequencer and store state
    t_state            r_state,     n_state;
    logic [CAP_W-1:0]  r_cap,       n_cap;
    logic [AW-1:0]     r_wp,        n_wp;
    logic [CAP_W-1:0]  r_held,      n_held;
    logic [TOTAL_W-1:0] r_total,    n_total;
    // read working registers
    logic [TOTAL_W-1:0] r_start,    n_start;
    logic [TOTAL_W-1:0] r_end,      n_end;
    logic [TOTAL_W-1:0] r_lo,       n_lo;     // window start, later the slot accumulator
    logic [TOTAL_W-1:0] r_hi,       n_hi;     // one past the newest index
    logic              r_neg,       n_neg;
    logic [CAP_W-1:0]  r_ofs,       n_ofs;
    logic [CW-1:0]     r_cnt,       n_cnt;
    logic              r_trunc,     n_trunc;
    logic [AW-1:0]     r_addr,      n_addr;
    // output register
    logic              r_out_valid, n_out_valid;
    t_shrb_out         r_out,       n_out;

    t_alu_op           w_op;
    t_alu_res          w_res;
    logic              w_out_free;
    logic              w_in_acc;
    logic              w_cfg_wr;
    logic [CAP_W-1:0]  w_cap_eff;
    logic [CAP_W-1:0]  w_new_cap;
    logic [CAP_W-1:0]  w_new_cap_eff;
    logic              w_big;
    logic              w_ram_we;
    logic              w_ram_re;
    logic [SAMPLE_BITS-1:0]       w_ram_wdata;
    logic [SAMPLE_BITS-1:0]       w_ram_rdata;
    logic [SAMPLE_BITS+SMP_W-1:0] w_wr_ext;
    logic [SAMPLE_BITS+SMP_W-1:0] w_rd_ext;

    // the one adder/subtractor every setup step and the append count go through
    shrb_addsub u_alu (
        .i_op  (w_op),
        .o_res (w_res)
    );

    shrb_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_wp),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (r_addr),
        .o_rdata (w_ram_rdata)
    );

    // handshakes
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE) || !w_out_free;
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // config port, always ready
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == CFG_IDX_CAP);
    assign prdata   = (paddr[2] == CFG_IDX_CAP) ? 32'(r_cap) : 32'd0;

    // capacity above the ring depth means the whole ring
    assign w_cap_eff     = (32'(r_cap) > 32'(STORE_DEPTH)) ? CAP_W'(STORE_DEPTH) : r_cap;
    assign w_new_cap     = pwdata[CAP_W-1:0];
    assign w_new_cap_eff = (32'(w_new_cap) > 32'(STORE_DEPTH)) ?
                           CAP_W'(STORE_DEPTH) : w_new_cap;

    // sample width conversion: zero extend then keep the low bits
    assign w_wr_ext    = {{SAMPLE_BITS{1'b0}}, i_in_data.sample_in};
    assign w_ram_wdata = w_wr_ext[SAMPLE_BITS-1:0];
    assign w_rd_ext    = {{SMP_W{1'b0}}, w_ram_rdata};

    assign w_ram_we = w_in_acc && (i_in_data.action == ACT_APPEND) && (w_cap_eff != '0);
    assign w_ram_re = (r_state == S_RD);

    // burst cut for the count step
    assign w_big = (w_res.sum[TOTAL_W-1:CW] != '0) ||
                   (w_res.sum[CW-1:0] > CW'(READ_BURST));

    // shared unit operand selection
    always_comb begin
        w_op.a   = r_total;
        w_op.b   = TOTAL_W'(1);
        w_op.sub = 1'b0;
        case (r_state)
            S_IDLE: begin
                w_op.a   = r_total;             // append count increment
                w_op.b   = TOTAL_W'(1);
                w_op.sub = 1'b0;
            end
            S_CHK: begin
                w_op.a   = r_end;
                w_op.b   = r_start;
                w_op.sub = 1'b1;
            end
            S_FIRST: begin
                w_op.a   = r_total;
                w_op.b   = TOTAL_W'(r_held);
                w_op.sub = 1'b1;
            end
            S_LAST: begin
                w_op.a   = r_lo;
                w_op.b   = TOTAL_W'(r_held);
                w_op.sub = 1'b0;
            end
            S_CLIPS: begin
                w_op.a   = r_start;
                w_op.b   = r_lo;
                w_op.sub = 1'b1;
            end
            S_CLIPE: begin
                w_op.a   = r_end;
                w_op.b   = r_hi;
                w_op.sub = 1'b1;
            end
            S_CNT: begin
                w_op.a   = r_end;
                w_op.b   = r_start;
                w_op.sub = 1'b1;
            end
            S_BASE: begin
                w_op.a   = TOTAL_W'(r_wp);
                w_op.b   = TOTAL_W'(r_held);
                w_op.sub = 1'b1;
            end
            S_WRAP1: begin
                w_op.a   = r_lo;
                w_op.b   = r_neg ? DEPTH_T : '0;
                w_op.sub = 1'b0;
            end
            S_OFS: begin
                w_op.a   = r_lo;
                w_op.b   = TOTAL_W'(r_ofs);
                w_op.sub = 1'b0;
            end
            S_WRAP2: begin
                w_op.a   = r_lo;
                w_op.b   = DEPTH_T;
                w_op.sub = 1'b1;
            end
            default: begin
                w_op.a   = r_total;
                w_op.b   = TOTAL_W'(1);
                w_op.sub = 1'b0;
            end
        endcase
    end

    // sequencer next state
    always_comb begin
        n_state     = r_state;
        n_cap       = r_cap;
        n_wp        = r_wp;
        n_held      = r_held;
        n_total     = r_total;
        n_start     = r_start;
        n_end       = r_end;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_neg       = r_neg;
        n_ofs       = r_ofs;
        n_cnt       = r_cnt;
        n_trunc     = r_trunc;
        n_addr      = r_addr;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    case (i_in_data.action)
                        ACT_APPEND: begin
                            n_total = w_res.sum;
                            if (w_cap_eff == '0) begin
                                n_held = '0;
                            end else begin
                                n_wp = (r_wp == AW'(STORE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
                                if (r_held < w_cap_eff) begin
                                    n_held = r_held + 1'b1;
                                end
                            end
                        end
                        ACT_CLEAR: begin
                            n_total = '0;
                            n_held  = '0;
                            n_wp    = '0;
                        end
                        default: begin
                        end
                    endcase
                    if (i_in_data.action == ACT_READ) begin
                        n_start = i_in_data.start_index;
                        n_end   = i_in_data.end_index;
                        n_state = S_CHK;
                    end else begin
                        // status item carries the counts after the update
                        n_out_valid        = 1'b1;
                        n_out.sample_out   = '0;
                        n_out.sample_valid = 1'b0;
                        n_out.last         = 1'b1;
                        n_out.truncated    = 1'b0;
                        n_out.total_count  = n_total;
                        n_out.stored_count = n_held;
                    end
                end
                // register write; lowering capacity drops the oldest samples
                if (w_cfg_wr) begin
                    n_cap = w_new_cap;
                    if (r_held > w_new_cap_eff) begin
                        n_held = w_new_cap_eff;
                    end
                end
            end
            S_CHK: begin
                n_state = (w_res.borrow || w_res.zero || r_held == '0) ? S_EMPTY : S_FIRST;
            end
            S_FIRST: begin
                // count wrapped below held: oldest sample sits at index zero
                n_lo    = w_res.borrow ? '0 : w_res.sum;
                n_state = S_LAST;
            end
            S_LAST: begin
                n_hi    = w_res.sum;
                n_state = S_CLIPS;
            end
            S_CLIPS: begin
                if (w_res.borrow) begin
                    n_start = r_lo;
                    n_ofs   = '0;
                end else begin
                    n_ofs   = w_res.sum[CAP_W-1:0];
                end
                n_state = S_CLIPE;
            end
            S_CLIPE: begin
                if (!w_res.borrow) begin
                    n_end = r_hi;
                end
                n_state = S_CNT;
            end
            S_CNT: begin
                if (w_res.borrow || w_res.zero) begin
                    n_state = S_EMPTY;
                end else begin
                    n_cnt   = w_big ? CW'(READ_BURST) : w_res.sum[CW-1:0];
                    n_trunc = w_big;
                    n_state = S_BASE;
                end
            end
            S_BASE: begin
                n_lo    = w_res.sum;
                n_neg   = w_res.borrow;
                n_state = S_WRAP1;
            end
            S_WRAP1: begin
                n_lo    = w_res.sum;
                n_state = S_OFS;
            end
            S_OFS: begin
                n_lo    = w_res.sum;
                n_state = S_WRAP2;
            end
            S_WRAP2: begin
                n_addr  = w_res.borrow ? r_lo[AW-1:0] : w_res.sum[AW-1:0];
                n_state = S_RD;
            end
            S_RD: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_out_valid        = 1'b1;
                    n_out.sample_out   = w_rd_ext[SMP_W-1:0];
                    n_out.sample_valid = 1'b1;
                    n_out.last         = (r_cnt == CW'(1));
                    n_out.truncated    = r_trunc;
                    n_out.total_count  = r_total;
                    n_out.stored_count = r_held;
                    n_cnt              = r_cnt - 1'b1;
                    n_addr = (r_addr == AW'(STORE_DEPTH - 1)) ? '0 : r_addr + 1'b1;
                    n_state = (r_cnt == CW'(1)) ? S_IDLE : S_RD;
                end
            end
            S_EMPTY: begin
                if (w_out_free) begin
                    n_out_valid        = 1'b1;
                    n_out.sample_out   = '0;
                    n_out.sample_valid = 1'b0;
                    n_out.last         = 1'b1;
                    n_out.truncated    = 1'b0;
                    n_out.total_count  = r_total;
                    n_out.stored_count = r_held;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cap       <= CAP_RESET;
            r_wp        <= '0;
            r_held      <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cap       <= n_cap;
            r_wp        <= n_wp;
            r_held      <= n_held;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
        r_start <= n_start;
        r_end   <= n_end;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_neg   <= n_neg;
        r_ofs   <= n_ofs;
        r_cnt   <= n_cnt;
        r_trunc <= n_trunc;
        r_addr  <= n_addr;
        r_out   <= n_out;
    end

`ifndef SYNTH
    // checks that the store holds no more than the effective capacity
    a_held_le_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= w_cap_eff)
        else $error("held count above effective capacity");

    // a streaming read always has samples left to send
    a_cnt_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT || r_state == S_RD) |-> (r_cnt != '0))
        else $error("read streaming with zero count");

    // read slot stays inside the ring
    a_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |-> (32'(r_addr) < 32'(STORE_DEPTH)))
        else $error("read address outside ring");

    // a returned sample is followed by the next read or the end of the item
    a_out_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && w_out_free && r_cnt != CW'(1)) |=> (r_state == S_RD))
        else $error("read stream broke off early");
`endif

endmodule

`default_nettype wire
